/* sv/stq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted timer queue
// Action and status codes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int TIMER_SLOTS = 16;
   localparam int TIME_BITS   = 32;
   localparam int SLOT_BITS   = $clog2(TIMER_SLOTS);
   localparam int COUNT_BITS  = $clog2(TIMER_SLOTS + 1);

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_ADJUST = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_TICK   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_PRESENT = 2'd2,
      ST_ABSENT  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REMOVE,
      S_INSERT,
      S_REPORT,
      S_TICK
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request
      logic remove;   // remove matching handle
      logic insert;   // insert captured handle and time
      logic pop;      // pop head
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic found;
      logic full;
      logic head_due;
      logic next_due;   // second cell is due as well
   } stat_type;

endpackage : stq_pkg
`default_nettype wire

/* sv/stq_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stq_datapath: row of timer cells with parallel shift insert and remove
// Each cell holds a handle and an expiry; valid cells are packed at the front.
// ----------------------------------------------------------------------------
module stq_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire stq_pkg::cmd_type              cmd,
   input  wire logic [3:0]                    req_handle,
   input  wire logic [31:0]                   req_expire,
   input  wire logic [31:0]                   req_now,
   output stq_pkg::stat_type                  stat,
   output logic [3:0]                         head_handle,
   output logic [stq_pkg::COUNT_BITS-1:0]     count
);
   import stq_pkg::*;

   logic [TIMER_SLOTS-1:0]   valid_ff, valid_in;
   logic [3:0]               handle_ff [TIMER_SLOTS];
   logic [3:0]               handle_in [TIMER_SLOTS];
   logic [TIME_BITS-1:0]     expiry_ff [TIMER_SLOTS];
   logic [TIME_BITS-1:0]     expiry_in [TIMER_SLOTS];
   logic [3:0]               hnd_ff;
   logic [TIME_BITS-1:0]     exp_ff, now_ff;
   logic [TIMER_SLOTS-1:0]   match, later, after_match;
   logic [COUNT_BITS-1:0]    count_ff, count_in;

   // per cell compare
   always_comb begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         match[i] = valid_ff[i] && (handle_ff[i] == hnd_ff);
         later[i] = !valid_ff[i] || (expiry_ff[i] > exp_ff);
      end
      after_match[0] = 1'b0;
      for (int i = 1; i < TIMER_SLOTS; i++)
         after_match[i] = after_match[i-1] | match[i-1];
   end

   assign stat.found    = |match;
   assign stat.full     = valid_ff[TIMER_SLOTS-1];
   assign stat.head_due = valid_ff[0] && (expiry_ff[0] <= now_ff);
   assign stat.next_due = valid_ff[1] && (expiry_ff[1] <= now_ff);
   assign head_handle   = handle_ff[0];
   assign count         = count_ff;

   // next cell contents
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         handle_in[i] = handle_ff[i];
         expiry_in[i] = expiry_ff[i];
      end
      if (cmd.remove || cmd.pop) begin
         for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (cmd.pop || after_match[i] || match[i]) begin
               if (i < TIMER_SLOTS - 1) begin
                  handle_in[i] = handle_ff[i+1];
                  expiry_in[i] = expiry_ff[i+1];
                  valid_in[i]  = valid_ff[i+1];
               end else begin
                  valid_in[i]  = 1'b0;
               end
            end
         end
         count_in = count_ff - 1'b1;
      end else if (cmd.insert) begin
         for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (later[i]) begin
               if (i == 0 || !later[i-1]) begin
                  handle_in[i] = hnd_ff;
                  expiry_in[i] = exp_ff;
               end else begin
                  handle_in[i] = handle_ff[i-1];
                  expiry_in[i] = expiry_ff[i-1];
               end
               valid_in[i] = (i == 0) ? 1'b1 : valid_ff[i-1];
            end
         end
         count_in = count_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         handle_ff[i] <= handle_in[i];
         expiry_ff[i] <= expiry_in[i];
      end
      if (cmd.load) begin
         hnd_ff <= req_handle;
         exp_ff <= req_expire[TIME_BITS-1:0];
         now_ff <= req_now[TIME_BITS-1:0];
      end
   end

endmodule : stq_datapath
`default_nettype wire

/* sv/stq_control.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stq_control: command sequencer of the sorted timer queue
// Checks the request, steps remove and insert, pops due entries on tick.
// ----------------------------------------------------------------------------
module stq_control (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [1:0]               req_action,
   input  wire stq_pkg::stat_type        stat,
   output logic                          busy,
   output stq_pkg::cmd_type              cmd,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_expired_valid,
   output logic                          rsp_last
);
   import stq_pkg::*;

   state_type  state_ff, state_in;
   action_type act_ff;
   status_type st_ff, st_in;
   logic       popped_ff, popped_in;

   // next state
   always_comb begin
      state_in  = state_ff;
      st_in     = st_ff;
      popped_in = popped_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               popped_in = 1'b0;
               st_in     = ST_OK;
               state_in  = (action_type'(req_action) == ACT_TICK) ? S_TICK : S_REMOVE;
            end
         end
         S_REMOVE: begin
            if (act_ff == ACT_ADD) begin
               if (stat.found) begin
                  st_in = ST_PRESENT; state_in = S_REPORT;
               end else if (stat.full) begin
                  st_in = ST_FULL; state_in = S_REPORT;
               end else begin
                  state_in = S_INSERT;
               end
            end else if (!stat.found) begin
               st_in = ST_ABSENT; state_in = S_REPORT;
            end else begin
               state_in = (act_ff == ACT_ADJUST) ? S_INSERT : S_REPORT;
            end
         end
         S_INSERT: state_in = S_REPORT;
         S_REPORT: state_in = S_IDLE;
         S_TICK: begin
            if (stat.head_due) popped_in = 1'b1;
            else               state_in  = popped_ff ? S_IDLE : S_REPORT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd               = '0;
      busy              = (state_ff != S_IDLE);
      rsp_strobe        = 1'b0;
      rsp_status        = st_ff;
      rsp_expired_valid = 1'b0;
      rsp_last          = 1'b0;
      case (state_ff)
         S_IDLE:   cmd.load = start;
         S_REMOVE: cmd.remove = (act_ff != ACT_ADD) && stat.found;
         S_INSERT: cmd.insert = 1'b1;
         S_REPORT: begin
            rsp_strobe = 1'b1;
            rsp_last   = 1'b1;
         end
         S_TICK: begin
            // a pop reports in the same cycle; last when the next head is not due
            cmd.pop           = stat.head_due;
            rsp_strobe        = stat.head_due;
            rsp_expired_valid = stat.head_due;
            rsp_last          = stat.head_due && !stat.next_due;
            rsp_status        = ST_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         st_ff     <= ST_OK;
         popped_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         st_ff     <= st_in;
         popped_ff <= popped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) act_ff <= action_type'(req_action);
   end

endmodule : stq_control
`default_nettype wire

/* sv/sorted_timer_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timer_queue: bounded timer queue kept sorted by expiry
// Add, adjust, delete and tick commands on up to 16 handles.
// ----------------------------------------------------------------------------
// Usage: drive req_* and raise start while busy is low; the command is taken
// at that edge and busy is high from the next cycle on. Each beat on rsp_*
// is marked by rsp_strobe for one cycle; rsp_last marks the final beat.
// Add that inserts and adjust that finds its handle: busy through the remove,
// insert and report states, with one beat in the report state.
// Delete, and add or adjust that ends in an error: busy through the remove
// and report states, with one beat in the report state.
// Tick pops due head entries one per cycle, a beat each with
// rsp_expired_valid high, starting in the tick state; each pop shows the count
// after it, and the pop whose next head is not due carries rsp_last. A tick
// that pops entries stays busy until the head is no longer due. A tick
// with nothing due gives one empty beat from the report state.
// The cell row shifts all entries in parallel for insert and remove. A new
// command is taken at the first edge with busy low.
// Reset empties the queue and returns the sequencer to idle.
// The receiver cannot stall: each beat lasts exactly one cycle.
// ----------------------------------------------------------------------------
module sorted_timer_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [3:0]  req_timer_handle,
   input  wire logic [31:0] req_expire_time,
   input  wire logic [31:0] req_current_time,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic             rsp_expired_valid,
   output logic [3:0]       rsp_expired_handle,
   output logic             rsp_last,
   output logic [4:0]       rsp_active_count
);
   import stq_pkg::*;

   cmd_type               cmd;
   stat_type              stat;
   logic [3:0]            head_handle;
   logic [COUNT_BITS-1:0] count;

   stq_control u_control (
      .clock, .reset, .start, .req_action, .stat, .busy, .cmd,
      .rsp_strobe, .rsp_status, .rsp_expired_valid, .rsp_last
   );

   stq_datapath u_datapath (
      .clock, .reset, .cmd,
      .req_handle(req_timer_handle), .req_expire(req_expire_time),
      .req_now(req_current_time), .stat, .head_handle, .count
   );

   // pop beats show the head and the count after the pop
   assign rsp_expired_handle = rsp_expired_valid ? head_handle : 4'd0;
   assign rsp_active_count   = 5'(rsp_expired_valid ? count - 1'b1 : count);

endmodule : sorted_timer_queue
`default_nettype wire
